/* hdl/rsfc_pkg.sv */
// ----------------------------------------------------------------------------
// rsfc_pkg
// shared constants and types of the rate-and-state friction core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsfc_pkg;

    localparam int DATA_W      = 32;          // width of fields and registers
    localparam int LOG_FRAC    = 30;          // fraction bits of log2 result
    localparam int MANT_W      = LOG_FRAC + 1; // mantissa in [1,2), Q1.30
    localparam int CNT_W       = 6;           // shift count / exponent width
    localparam int NORM_STAGES = 6;           // shifts of 32,16,8,4,2,1
    localparam int LN2_W       = 28;
    localparam int LN_W        = 31;          // ln term stays below 2^30
    localparam int PROD_W      = 64;
    localparam int PIPE_EXTRA  = 42;          // stages after the divider chain

    localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;
    localparam logic [CNT_W-1:0] EXP_BIAS = 6'd32;

    typedef enum logic [2:0] {
        REG_BASE_COEF  = 3'd0,
        REG_VEL_GAIN   = 3'd1,
        REG_STATE_GAIN = 3'd2,
        REG_VEL_SCALE  = 3'd3,
        REG_STATE_SCALE = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/rate_state_friction_coefficient_core.sv */
// ----------------------------------------------------------------------------
// rate_state_friction_coefficient_core
// mu = mu0 + a*ln(v/v0 + 1) + b*ln(theta/theta0 + 1), signed Q16.16, saturated
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken every cycle (busy stays low) and each
// result shows on result_valid for one cycle. The path of an item runs
// through the restoring divider chain (one quotient bit per cell), the
// six-step normalizer and the 30 squaring cells of the log2 chain. The result
// cannot be stalled. Configuration is always ready and must only be written
// while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rate_state_friction_coefficient_core #(
    parameter int TAG_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [TAG_BITS-1:0]  node_tag,
    input  wire logic [31:0]          sliding_velocity,
    input  wire logic [31:0]          state_theta,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic                      result_valid,
    output logic      [TAG_BITS-1:0]  result_tag,
    output logic      [31:0]          friction_value,
    output logic                      saturated
);

    localparam int DW = rsfc_pkg::DATA_W;
    localparam int QW = DW + FRAC_BITS;
    localparam int YW = QW + 1;
    localparam int L  = QW + rsfc_pkg::PIPE_EXTRA;
    localparam int NS = rsfc_pkg::NORM_STAGES;
    localparam int SQ = rsfc_pkg::LOG_FRAC;

    // configuration registers
    logic [DW-1:0] base_reg, vgain_reg, sgain_reg, vscale_reg, sscale_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            vgain_reg  <= '0;
            sgain_reg  <= '0;
            vscale_reg <= DW'(1) << FRAC_BITS;
            sscale_reg <= DW'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rsfc_pkg::REG_BASE_COEF:   base_reg  <= cfg_data;
                rsfc_pkg::REG_VEL_GAIN:    vgain_reg <= cfg_data;
                rsfc_pkg::REG_STATE_GAIN:  sgain_reg <= cfg_data;
                // a zero scale acts as one lsb
                rsfc_pkg::REG_VEL_SCALE:   vscale_reg <= (cfg_data == '0) ? DW'(1) : cfg_data;
                rsfc_pkg::REG_STATE_SCALE: sscale_reg <= (cfg_data == '0) ? DW'(1) : cfg_data;
                default: ;
            endcase
        end
    end

    // item valid and tag travel alongside the datapath
    logic [L-1:0]        valid_reg;
    logic [TAG_BITS-1:0] tag_reg [0:L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[L-2:0], start && !busy};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= node_tag;
        for (int i = 1; i < L; i++)
            tag_reg[i] <= tag_reg[i-1];
    end

    // two identical log lanes: velocity and theta
    logic [DW-1:0]        lane_x     [0:1];
    logic [DW-1:0]        lane_scale [0:1];
    logic signed [DW-1:0] lane_gain  [0:1];
    logic signed [rsfc_pkg::PROD_W-1:0] lane_term [0:1];

    assign lane_x[0]     = sliding_velocity;
    assign lane_x[1]     = state_theta;
    assign lane_scale[0] = vscale_reg;
    assign lane_scale[1] = sscale_reg;
    assign lane_gain[0]  = vgain_reg;
    assign lane_gain[1]  = sgain_reg;

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        logic [DW-1:0] rem_w [0:QW];
        logic [QW-1:0] dvd_w [0:QW];
        logic [QW-1:0] quo_w [0:QW];

        assign rem_w[0] = '0;
        assign dvd_w[0] = {lane_x[ln], {FRAC_BITS{1'b0}}};
        assign quo_w[0] = '0;

        for (genvar k = 0; k < QW; k++)
        begin : g_div
            rsfc_div_cell #(.QW(QW)) u_div (
                .clk     (clk),
                .divisor (lane_scale[ln]),
                .rem_in  (rem_w[k]),
                .dvd_in  (dvd_w[k]),
                .quo_in  (quo_w[k]),
                .rem_out (rem_w[k+1]),
                .dvd_out (dvd_w[k+1]),
                .quo_out (quo_w[k+1])
            );
        end

        // y = ratio + 1.0
        logic [YW-1:0] y_reg;

        always_ff @(posedge clk)
        begin
            y_reg <= {1'b0, quo_w[QW]} + (YW'(1) << FRAC_BITS);
        end

        logic [YW-1:0]              word_w [0:NS];
        logic [rsfc_pkg::CNT_W-1:0] cnt_w  [0:NS];

        assign word_w[0] = y_reg;
        assign cnt_w[0]  = '0;

        for (genvar j = 0; j < NS; j++)
        begin : g_norm
            rsfc_norm_cell #(.YW(YW), .SHIFT(32 >> j)) u_norm (
                .clk      (clk),
                .word_in  (word_w[j]),
                .cnt_in   (cnt_w[j]),
                .word_out (word_w[j+1]),
                .cnt_out  (cnt_w[j+1])
            );
        end

        logic [rsfc_pkg::MANT_W-1:0]   mant_w [0:SQ];
        logic [rsfc_pkg::LOG_FRAC-1:0] frac_w [0:SQ];
        logic [rsfc_pkg::CNT_W-1:0]    exp_w  [0:SQ];

        // exponent = msb position - FRAC_BITS = 32 - leading zeros
        assign mant_w[0] = word_w[NS][YW-1 -: rsfc_pkg::MANT_W];
        assign frac_w[0] = '0;
        assign exp_w[0]  = rsfc_pkg::EXP_BIAS - cnt_w[NS];

        for (genvar s = 0; s < SQ; s++)
        begin : g_sq
            rsfc_sq_cell u_sq (
                .clk      (clk),
                .mant_in  (mant_w[s]),
                .frac_in  (frac_w[s]),
                .exp_in   (exp_w[s]),
                .mant_out (mant_w[s+1]),
                .frac_out (frac_w[s+1]),
                .exp_out  (exp_w[s+1])
            );
        end

        // log2 times ln2, split into exponent and fraction products
        logic [rsfc_pkg::CNT_W+rsfc_pkg::LN2_W-1:0]    pa_reg;
        logic [rsfc_pkg::LOG_FRAC+rsfc_pkg::LN2_W-1:0] pb_reg;
        logic [rsfc_pkg::PROD_W-1:0]                   ln_full;
        logic [rsfc_pkg::PROD_W-1:0]                   ln_shift;
        logic [rsfc_pkg::LN_W-1:0]                     ln_reg;
        logic signed [DW-1:0]                          ln_s;
        logic signed [rsfc_pkg::PROD_W-1:0]            prod;

        always_ff @(posedge clk)
        begin
            pa_reg <= exp_w[SQ] * rsfc_pkg::LN2_Q28;
            pb_reg <= frac_w[SQ] * rsfc_pkg::LN2_Q28;
        end

        assign ln_full  = (rsfc_pkg::PROD_W'(pa_reg) << rsfc_pkg::LOG_FRAC)
                        + rsfc_pkg::PROD_W'(pb_reg);
        assign ln_shift = ln_full >> (58 - FRAC_BITS);

        always_ff @(posedge clk)
        begin
            ln_reg <= ln_shift[rsfc_pkg::LN_W-1:0];
        end

        assign ln_s = {1'b0, ln_reg};
        assign prod = lane_gain[ln] * ln_s;

        logic signed [rsfc_pkg::PROD_W-1:0] term_reg;

        always_ff @(posedge clk)
        begin
            term_reg <= prod >>> FRAC_BITS;
        end

        assign lane_term[ln] = term_reg;
    end

    // sum and saturation
    logic signed [rsfc_pkg::PROD_W-1:0] sum_reg;
    logic signed [DW-1:0]               base_s;
    logic [DW-1:0]                      fric_reg;
    logic                               sat_reg;

    assign base_s = base_reg;

    always_ff @(posedge clk)
    begin
        sum_reg <= rsfc_pkg::PROD_W'(base_s) + lane_term[0] + lane_term[1];
        if (sum_reg > rsfc_pkg::PROD_W'(32'sh7fffffff))
        begin
            fric_reg <= 32'h7fffffff;
            sat_reg  <= 1'b1;
        end
        else if (sum_reg < -rsfc_pkg::PROD_W'(64'sh80000000))
        begin
            fric_reg <= 32'h80000000;
            sat_reg  <= 1'b1;
        end
        else
        begin
            fric_reg <= sum_reg[DW-1:0];
            sat_reg  <= 1'b0;
        end
    end

    assign result_valid   = valid_reg[L-1];
    assign result_tag     = tag_reg[L-1];
    assign friction_value = fric_reg;
    assign saturated      = sat_reg;

endmodule

`default_nettype wire

/* hdl/rsfc_div_cell.sv */
// ----------------------------------------------------------------------------
// rsfc_div_cell
// one restoring division step: brings in one dividend bit, emits one quotient bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsfc_div_cell #(
    parameter int QW = 48
) (
    input  wire logic                          clk,
    input  wire logic [rsfc_pkg::DATA_W-1:0]   divisor,
    input  wire logic [rsfc_pkg::DATA_W-1:0]   rem_in,
    input  wire logic [QW-1:0]                 dvd_in,
    input  wire logic [QW-1:0]                 quo_in,
    output logic      [rsfc_pkg::DATA_W-1:0]   rem_out,
    output logic      [QW-1:0]                 dvd_out,
    output logic      [QW-1:0]                 quo_out
);

    logic [rsfc_pkg::DATA_W:0]   trial;
    logic                        fits;
    logic [rsfc_pkg::DATA_W:0]   diff;

    assign trial = {rem_in, dvd_in[QW-1]};
    assign fits  = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        rem_out <= fits ? diff[rsfc_pkg::DATA_W-1:0] : trial[rsfc_pkg::DATA_W-1:0];
        dvd_out <= {dvd_in[QW-2:0], 1'b0};
        quo_out <= {quo_in[QW-2:0], fits};
    end

endmodule

`default_nettype wire

/* hdl/rsfc_norm_cell.sv */
// ----------------------------------------------------------------------------
// rsfc_norm_cell
// one step of the leading-one normalizer: shift left by SHIFT if the top is clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsfc_norm_cell #(
    parameter int YW    = 49,
    parameter int SHIFT = 32
) (
    input  wire logic                        clk,
    input  wire logic [YW-1:0]               word_in,
    input  wire logic [rsfc_pkg::CNT_W-1:0]  cnt_in,
    output logic      [YW-1:0]               word_out,
    output logic      [rsfc_pkg::CNT_W-1:0]  cnt_out
);

    logic top_clear;

    assign top_clear = (word_in[YW-1 -: SHIFT] == '0);

    always_ff @(posedge clk)
    begin
        if (top_clear)
        begin
            word_out <= word_in << SHIFT;
            cnt_out  <= cnt_in + rsfc_pkg::CNT_W'(SHIFT);
        end
        else
        begin
            word_out <= word_in;
            cnt_out  <= cnt_in;
        end
    end

endmodule

`default_nettype wire

/* hdl/rsfc_sq_cell.sv */
// ----------------------------------------------------------------------------
// rsfc_sq_cell
// one log2 fraction bit: square the mantissa, halve it when it reaches 2.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsfc_sq_cell (
    input  wire logic                           clk,
    input  wire logic [rsfc_pkg::MANT_W-1:0]    mant_in,
    input  wire logic [rsfc_pkg::LOG_FRAC-1:0]  frac_in,
    input  wire logic [rsfc_pkg::CNT_W-1:0]     exp_in,
    output logic      [rsfc_pkg::MANT_W-1:0]    mant_out,
    output logic      [rsfc_pkg::LOG_FRAC-1:0]  frac_out,
    output logic      [rsfc_pkg::CNT_W-1:0]     exp_out
);

    logic [2*rsfc_pkg::MANT_W-1:0] sq;
    logic [rsfc_pkg::MANT_W:0]     sq_top;

    assign sq     = mant_in * mant_in;
    assign sq_top = sq[rsfc_pkg::LOG_FRAC +: rsfc_pkg::MANT_W + 1];

    always_ff @(posedge clk)
    begin
        mant_out <= sq_top[rsfc_pkg::MANT_W] ? sq_top[rsfc_pkg::MANT_W:1]
                                             : sq_top[rsfc_pkg::MANT_W-1:0];
        frac_out <= {frac_in[rsfc_pkg::LOG_FRAC-2:0], sq_top[rsfc_pkg::MANT_W]};
        exp_out  <= exp_in;
    end

endmodule

`default_nettype wire

/* hdl/rsfc_checker.sv */
// ----------------------------------------------------------------------------
// rsfc_checker
// port-level checks of the friction core: latency, tag order, clipping
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsfc_checker #(
    parameter int TAG_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [TAG_BITS-1:0] node_tag,
    input wire logic                result_valid,
    input wire logic [TAG_BITS-1:0] result_tag,
    input wire logic [31:0]         friction_value,
    input wire logic                saturated
);

    localparam int LAT = 32 + FRAC_BITS + rsfc_pkg::PIPE_EXTRA;

    // every accepted item comes back after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT result_valid)
        else $error("missing result after start transfer");

    // no result without an item accepted the same latency earlier
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LAT))
        else $error("result without matching start transfer");

    a_tag_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_tag == $past(node_tag, LAT))
        else $error("result tag does not match accepted tag");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (friction_value == 32'h7fffffff || friction_value == 32'h80000000))
        else $error("saturated result not at a range limit");

endmodule

bind rate_state_friction_coefficient_core rsfc_checker #(
    .TAG_BITS  (TAG_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_rsfc_checker (.*);

`default_nettype wire

/* tb/tb_rate_state_friction_coefficient_core.sv */
// ----------------------------------------------------------------------------
// tb_rate_state_friction_coefficient_core
// checks mu = mu0 + a*ln(v/v0+1) + b*ln(theta/theta0+1) against a fixed-point
// predictor over a directed table and random phases with varied coefficients
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_rate_state_friction_coefficient_core;

    localparam int TAG_W          = 16;
    localparam int FRAC_W         = 16;
    localparam int PIPE_LATENCY   = 32 + FRAC_W + 42;
    localparam int DRAIN_CYCLES   = PIPE_LATENCY + 10;
    localparam int STALL_LIMIT    = 5000;
    localparam int NUM_REGS       = 5;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 192;
    localparam int MAX_REPORTS    = 10;
    localparam logic [2:0] CFG_INDEX_SPARE = 3'd7;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [31:0]      mu;
        logic             sat;
    } friction_t;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [31:0]      vel;
        logic [31:0]      theta;
        bit               typed;
        logic [31:0]      mu;
        logic             sat;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [TAG_W-1:0] node_tag = '0;
    logic [31:0] sliding_velocity = '0;
    logic [31:0] state_theta = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic result_valid;
    logic [TAG_W-1:0] result_tag;
    logic [31:0] friction_value;
    logic saturated;

    logic [31:0] coef_regs [NUM_REGS];
    friction_t pending_results [$];
    int mismatches = 0;
    int stall_cycles = 0;

    rate_state_friction_coefficient_core #(
        .TAG_BITS (TAG_W),
        .FRAC_BITS(FRAC_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .node_tag        (node_tag),
        .sliding_velocity(sliding_velocity),
        .state_theta     (state_theta),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .result_tag      (result_tag),
        .friction_value  (friction_value),
        .saturated       (saturated)
    );

    always #10 clk = ~clk;

    // ln(x/scale + 1) in Q.FRAC_W through a squaring log2 chain
    function automatic logic [63:0] ln_ratio(input logic [31:0] x, input logic [31:0] scale);
        logic [63:0] divisor;
        logic [63:0] y;
        logic [63:0] mant;
        logic [63:0] log2_acc;
        int msb;
        divisor = (scale == 0) ? 64'd1 : {32'd0, scale};
        y = (({32'd0, x}) << FRAC_W) / divisor + (64'd1 << FRAC_W);
        msb = 63;
        while (msb > 0 && !y[msb])
            msb--;
        if (msb > rsfc_pkg::LOG_FRAC)
            mant = y >> (msb - rsfc_pkg::LOG_FRAC);
        else
            mant = y << (rsfc_pkg::LOG_FRAC - msb);
        log2_acc = 64'(msb - FRAC_W) << rsfc_pkg::LOG_FRAC;
        for (int i = rsfc_pkg::LOG_FRAC - 1; i >= 0; i--)
        begin
            mant = (mant * mant) >> rsfc_pkg::LOG_FRAC;
            if (mant >= (64'd2 << rsfc_pkg::LOG_FRAC))
            begin
                mant = mant >> 1;
                log2_acc[i] = 1'b1;
            end
        end
        return (log2_acc * 64'(rsfc_pkg::LN2_Q28)) >> (58 - FRAC_W);
    endfunction

    // floor(gain * ln / 2^FRAC_W)
    function automatic logic signed [63:0] gain_times_ln(input logic [31:0] gain,
                                                        input logic [63:0] ln);
        logic signed [63:0] prod;
        prod = $signed({{32{gain[31]}}, gain}) * $signed(ln);
        return prod >>> FRAC_W;
    endfunction

    function automatic friction_t friction_of(input logic [TAG_W-1:0] tag,
                                              input logic [31:0] vel,
                                              input logic [31:0] theta);
        logic signed [63:0] mu_sum;
        logic [31:0] base;
        friction_t res;
        base = coef_regs[rsfc_pkg::REG_BASE_COEF];
        mu_sum = $signed({{32{base[31]}}, base})
               + gain_times_ln(coef_regs[rsfc_pkg::REG_VEL_GAIN],
                               ln_ratio(vel, coef_regs[rsfc_pkg::REG_VEL_SCALE]))
               + gain_times_ln(coef_regs[rsfc_pkg::REG_STATE_GAIN],
                               ln_ratio(theta, coef_regs[rsfc_pkg::REG_STATE_SCALE]));
        res.tag = tag;
        res.sat = 1'b0;
        if (mu_sum > 64'sh7FFF_FFFF)
        begin
            mu_sum = 64'sh7FFF_FFFF;
            res.sat = 1'b1;
        end
        else if (mu_sum < -64'sh8000_0000)
        begin
            mu_sum = -64'sh8000_0000;
            res.sat = 1'b1;
        end
        res.mu = mu_sum[31:0];
        return res;
    endfunction

    // one burst of register writes, valid held high across the burst
    task automatic load_coefficients(input logic [31:0] vals [NUM_REGS], input bit spare);
        for (int r = 0; r < NUM_REGS + 1; r++)
        begin
            if (r == NUM_REGS && !spare)
                break;
            cfg_valid <= 1'b1;
            cfg_index <= (r == NUM_REGS) ? CFG_INDEX_SPARE : 3'(r);
            cfg_data  <= (r == NUM_REGS) ? $urandom : vals[r];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (r < NUM_REGS)
                coef_regs[r] = vals[r];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [TAG_W-1:0] tag, input logic [31:0] vel,
                             input logic [31:0] theta, input bit calm,
                             input bit typed, input friction_t typed_res);
        if (!calm)
        begin
            while ($urandom_range(99, 0) < 26)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start            <= 1'b1;
        node_tag         <= tag;
        sliding_velocity <= vel;
        state_theta      <= theta;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(typed ? typed_res : friction_of(tag, vel, theta));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_field();
        case ($urandom_range(5, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h0004_0000, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(4, 0))
            0: return $urandom;
            1: return 32'($signed($urandom_range(32'h0002_0000, 0)) - 32'sh0001_0000);
            default: return $urandom_range(32'h0001_0000, 0);
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(4, 0))
            0: return $urandom;
            1: return $urandom_range(16, 0);
            default: return $urandom_range(32'h0010_0000, 32'h0000_0100);
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        friction_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result tag=%h mu=%h sat=%b",
                             result_tag, friction_value, saturated);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_tag !== want.tag || friction_value !== want.mu
                    || saturated !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected tag=%h mu=%h sat=%b, got tag=%h mu=%h sat=%b",
                                 want.tag, want.mu, want.sat,
                                 result_tag, friction_value, saturated);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t table_rows [$];
        logic [31:0] vals [NUM_REGS];
        friction_t typed_res;

        coef_regs[rsfc_pkg::REG_BASE_COEF]   = 32'd0;
        coef_regs[rsfc_pkg::REG_VEL_GAIN]    = 32'd0;
        coef_regs[rsfc_pkg::REG_STATE_GAIN]  = 32'd0;
        coef_regs[rsfc_pkg::REG_VEL_SCALE]   = 32'h0001_0000;
        coef_regs[rsfc_pkg::REG_STATE_SCALE] = 32'h0001_0000;

        // after reset every gain is zero, so mu reads back as zero
        table_rows.push_back('{16'h0000, 32'h0000_0000, 32'h0000_0000, 1, 32'd0, 1'b0});
        table_rows.push_back('{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 1'b0});
        table_rows.push_back('{16'h5A5A, 32'h0001_0000, 32'h0000_0000, 1, 32'd0, 1'b0});
        // edge shapes checked by prediction
        table_rows.push_back('{16'hA5A5, 32'h0000_0001, 32'hFFFF_FFFF, 0, 32'd0, 1'b0});
        table_rows.push_back('{16'h0001, 32'h0000_FFFF, 32'h0001_0000, 0, 32'd0, 1'b0});
        table_rows.push_back('{16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'd0, 1'b0});
        table_rows.push_back('{16'h7FFF, 32'h0000_0000, 32'h0000_0001, 0, 32'd0, 1'b0});
        table_rows.push_back('{16'h1234, 32'h0003_0000, 32'h0000_8000, 0, 32'd0, 1'b0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            typed_res = '{table_rows[i].tag, table_rows[i].mu, table_rows[i].sat};
            send_item(table_rows[i].tag, table_rows[i].vel, table_rows[i].theta, 0,
                      table_rows[i].typed, typed_res);
        end
        wait_idle();

        // positive extremes with zero scales: both logs at their largest
        vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0};
        load_coefficients(vals, 1);
        typed_res = '{16'h00FF, 32'h7FFF_FFFF, 1'b1};
        send_item(16'h00FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, typed_res);
        foreach (table_rows[i])
            send_item(table_rows[i].tag, table_rows[i].vel, table_rows[i].theta, 0, 0, typed_res);
        wait_idle();

        // negative extremes with largest scales
        vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        load_coefficients(vals, 1);
        foreach (table_rows[i])
            send_item(table_rows[i].tag, table_rows[i].vel, table_rows[i].theta, 0, 0, typed_res);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            vals = '{pick_gain(), pick_gain(), pick_gain(), pick_scale(), pick_scale()};
            if (ph == 2)
                vals[rsfc_pkg::REG_BASE_COEF] = $urandom;
            load_coefficients(vals, ph[0]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(16'($urandom), pick_field(), pick_field(), ph == 3, 0, typed_res);
            wait_idle();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
